FILE: hw/rtl/ps2mpt_pkg.sv
// Shared types and constants for the PS/2 mouse packet tracker.
// Used by the configuration, controller, datapath and top-level modules.
// No dependencies.
package ps2mpt_pkg;

  // Coordinate and arithmetic widths.
  localparam int CoordW     = 16;            // kept cursor position
  localparam int BoundW     = 16;            // bound registers
  localparam int MoveW      = CoordW + 1;    // actual change after clamping
  localparam int SumW       = CoordW + 2;    // cursor plus move before clamping
  localparam int AxisW      = 16;            // signed move through both gain steps
  localparam int AbsW       = AxisW - 1;     // magnitude of a move
  localparam int GainW      = 10;
  localparam int ProdW      = 22;            // magnitude times gain
  localparam int MagW       = 24;            // dx*dx + dy*dy
  localparam int QuotW      = AxisW;
  localparam int NumBtn     = 3;
  localparam int PendW      = NumBtn + 1;    // move slot plus one slot per button
  localparam int ByteW      = 8;
  localparam int DataW      = 72;            // output tdata, padded to whole bytes
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 16;

  // Division by one hundred: floor(p * DivRecip / 2^RecipShift) is the true
  // quotient or one less for every product below 2^ProdW.
  localparam int              Divisor    = 100;
  localparam int              RecipShift = 22;
  localparam int              RecipW     = 16;
  localparam logic [RecipW-1:0] DivRecip = 16'd41943;
  localparam int              MagLimit   = 100;

  // Header bits.
  localparam int HdrSyncBit = 3;
  localparam int HdrXSign   = 4;
  localparam int HdrYSign   = 5;

  // Reset values.
  localparam logic [GainW-1:0]         GainReset     = 10'd100;
  localparam logic signed [CoordW-1:0] CursorXReset  = CoordW'(400);
  localparam logic signed [CoordW-1:0] CursorYReset  = CoordW'(300);
  localparam logic signed [BoundW-1:0] BoundRightRst = BoundW'(799);
  localparam logic signed [BoundW-1:0] BoundTopRst   = BoundW'(599);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SENS   = 3'd0,
    CFG_ACCEL  = 3'd1,
    CFG_INV_H  = 3'd2,
    CFG_INV_V  = 3'd3,
    CFG_LEFT   = 3'd4,
    CFG_BOTTOM = 3'd5,
    CFG_RIGHT  = 3'd6,
    CFG_TOP    = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    EV_MOVE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2
  } ev_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RECIP,
    ST_QUOT,
    ST_SQ,
    ST_MAG,
    ST_CLAMP,
    ST_EMIT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_RECIP,
    OP_QUOT,
    OP_SQ,
    OP_MAG,
    OP_CLAMP,
    OP_EMIT
  } op_e;

  typedef struct packed {
    logic [GainW-1:0]         sens;
    logic [GainW-1:0]         accel;
    logic                     inv_h;
    logic                     inv_v;
    logic signed [BoundW-1:0] left;
    logic signed [BoundW-1:0] bottom;
    logic signed [BoundW-1:0] right;
    logic signed [BoundW-1:0] top;
  } cfg_t;

  typedef struct packed {
    op_e  op;
    logic axis;      // 0 selects X, 1 selects Y
    logic gain_acc;  // 0 sensitivity, 1 acceleration
    logic hdr_we;
    logic xb_we;
  } cmd_t;

  typedef struct packed {
    logic hdr_ok;
    logic mag_big;
    logic pend_any;
    logic pend_last;
    logic out_free;
  } sts_t;

endpackage

FILE: hw/rtl/ps2_mouse_packet_tracker.sv
// Top level of the PS/2 mouse packet tracker.
// Instantiates ps2mpt_cfg, ps2mpt_ctrl and ps2mpt_dpath; depends on ps2mpt_pkg.
//
//  Channel   Direction  Handshake                   Payload
//  s_axis    in         s_axis_tvalid/tready        tdata[7:0] rx_byte
//  m_axis    out        m_axis_tvalid/tready        tdata, tuser event_kind, tlast last_of_run
//  cfg       in         cfg_valid_i/cfg_ready_o     cfg_index_i, cfg_data_i
//
// The first two bytes of a packet are only stored. The third byte of a valid
// packet starts the sensitivity step and, when the squared move exceeds the
// limit, the acceleration step. Each gain step runs both axes through the
// shared multiplier and the divide-by-100 unit by multiply, reciprocal and
// correction steps; the clamp and the events follow. A bad header drops the packet.
// Reset clears the byte count and buttons, sets the cursor to (400, 300) and loads the configuration defaults.
// A stalled output holds the last word while the next byte is already taken.
module ps2_mouse_packet_tracker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [ps2mpt_pkg::ByteW-1:0]        s_axis_tdata_i,   // [7:0] rx_byte
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [15:0] pos_x, [31:16] pos_y, [48:32] move_dx, [65:49] move_dy,
  // [67:66] button_number, [71:68] zero
  output logic [ps2mpt_pkg::DataW-1:0]        m_axis_tdata_o,
  output logic [1:0]                          m_axis_tuser_o,   // [1:0] event_kind
  output logic                                m_axis_tlast_o,   // last_of_run
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ps2mpt_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [ps2mpt_pkg::CfgDataW-1:0]     cfg_data_i
);

  ps2mpt_pkg::cfg_t cfg;
  ps2mpt_pkg::cmd_t cmd;
  ps2mpt_pkg::sts_t sts;

  ps2mpt_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ps2mpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ps2mpt_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .rx_byte_i   (s_axis_tdata_i),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_kind_o  (m_axis_tuser_o),
    .out_data_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

FILE: hw/rtl/ps2mpt_cfg.sv
// Configuration register file of the PS/2 mouse packet tracker.
// Depends on ps2mpt_pkg for the register index codes and the cfg_t struct.
module ps2mpt_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ps2mpt_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [ps2mpt_pkg::CfgDataW-1:0]    cfg_data_i,
  output ps2mpt_pkg::cfg_t                   cfg_o
);

  ps2mpt_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (ps2mpt_pkg::cfg_idx_e'(cfg_index_i))
        ps2mpt_pkg::CFG_SENS:   cfg_d.sens   = cfg_data_i[ps2mpt_pkg::GainW-1:0];
        ps2mpt_pkg::CFG_ACCEL:  cfg_d.accel  = cfg_data_i[ps2mpt_pkg::GainW-1:0];
        ps2mpt_pkg::CFG_INV_H:  cfg_d.inv_h  = cfg_data_i[0];
        ps2mpt_pkg::CFG_INV_V:  cfg_d.inv_v  = cfg_data_i[0];
        ps2mpt_pkg::CFG_LEFT:   cfg_d.left   = cfg_data_i[ps2mpt_pkg::BoundW-1:0];
        ps2mpt_pkg::CFG_BOTTOM: cfg_d.bottom = cfg_data_i[ps2mpt_pkg::BoundW-1:0];
        ps2mpt_pkg::CFG_RIGHT:  cfg_d.right  = cfg_data_i[ps2mpt_pkg::BoundW-1:0];
        ps2mpt_pkg::CFG_TOP:    cfg_d.top    = cfg_data_i[ps2mpt_pkg::BoundW-1:0];
        default:                cfg_d        = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sens   <= ps2mpt_pkg::GainReset;
      cfg_q.accel  <= ps2mpt_pkg::GainReset;
      cfg_q.inv_h  <= 1'b0;
      cfg_q.inv_v  <= 1'b0;
      cfg_q.left   <= '0;
      cfg_q.bottom <= '0;
      cfg_q.right  <= ps2mpt_pkg::BoundRightRst;
      cfg_q.top    <= ps2mpt_pkg::BoundTopRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: hw/rtl/ps2mpt_ctrl.sv
// Sequencing state machine of the PS/2 mouse packet tracker.
// Depends on ps2mpt_pkg; drives the datapath through cmd_t and reads sts_t.
module ps2mpt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ps2mpt_pkg::sts_t    sts_i,
  output ps2mpt_pkg::cmd_t    cmd_o
);

  ps2mpt_pkg::state_e state_q, state_d;
  logic [1:0]         cnt_q, cnt_d;
  logic               axis_q, axis_d;
  logic               acc_q, acc_d;

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    axis_d         = axis_q;
    acc_d          = acc_q;
    in_ready_o     = 1'b0;
    cmd_o.op       = ps2mpt_pkg::OP_NONE;
    cmd_o.axis     = axis_q;
    cmd_o.gain_acc = acc_q;
    cmd_o.hdr_we   = 1'b0;
    cmd_o.xb_we    = 1'b0;

    unique case (state_q)
      ps2mpt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          priority case (cnt_q)
            2'd0: begin
              cmd_o.hdr_we = 1'b1;
              cnt_d        = 2'd1;
            end
            2'd1: begin
              cmd_o.xb_we = 1'b1;
              cnt_d       = 2'd2;
            end
            default: begin
              // The third byte completes the packet; a bad header drops it.
              cnt_d = 2'd0;
              if (sts_i.hdr_ok) begin
                cmd_o.op = ps2mpt_pkg::OP_LOAD;
                axis_d   = 1'b0;
                acc_d    = 1'b0;
                state_d  = ps2mpt_pkg::ST_MUL;
              end
            end
          endcase
        end
      end
      ps2mpt_pkg::ST_MUL: begin
        cmd_o.op = ps2mpt_pkg::OP_MUL;
        state_d  = ps2mpt_pkg::ST_RECIP;
      end
      ps2mpt_pkg::ST_RECIP: begin
        cmd_o.op = ps2mpt_pkg::OP_RECIP;
        state_d  = ps2mpt_pkg::ST_QUOT;
      end
      ps2mpt_pkg::ST_QUOT: begin
        cmd_o.op = ps2mpt_pkg::OP_QUOT;
        if (!axis_q) begin
          axis_d  = 1'b1;
          state_d = ps2mpt_pkg::ST_MUL;
        end else begin
          axis_d  = 1'b0;
          state_d = acc_q ? ps2mpt_pkg::ST_CLAMP : ps2mpt_pkg::ST_SQ;
        end
      end
      ps2mpt_pkg::ST_SQ: begin
        cmd_o.op = ps2mpt_pkg::OP_SQ;
        state_d  = ps2mpt_pkg::ST_MAG;
      end
      ps2mpt_pkg::ST_MAG: begin
        cmd_o.op = ps2mpt_pkg::OP_MAG;
        if (sts_i.mag_big) begin
          acc_d   = 1'b1;
          state_d = ps2mpt_pkg::ST_MUL;
        end else begin
          state_d = ps2mpt_pkg::ST_CLAMP;
        end
      end
      ps2mpt_pkg::ST_CLAMP: begin
        cmd_o.op = ps2mpt_pkg::OP_CLAMP;
        state_d  = ps2mpt_pkg::ST_EMIT;
      end
      ps2mpt_pkg::ST_EMIT: begin
        if (!sts_i.pend_any) begin
          state_d = ps2mpt_pkg::ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.op = ps2mpt_pkg::OP_EMIT;
          if (sts_i.pend_last) begin
            state_d = ps2mpt_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = ps2mpt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ps2mpt_pkg::ST_IDLE;
      cnt_q   <= 2'd0;
      axis_q  <= 1'b0;
      acc_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      axis_q  <= axis_d;
      acc_q   <= acc_d;
    end
  end

endmodule

FILE: hw/rtl/ps2mpt_dpath.sv
// Datapath of the PS/2 mouse packet tracker: byte registers, shared multiplier,
// divide-by-100 unit, clamp, cursor and button state, and the output register.
// Depends on ps2mpt_pkg; commanded by ps2mpt_ctrl through cmd_t.
module ps2mpt_dpath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ps2mpt_pkg::cfg_t                     cfg_i,
  input  ps2mpt_pkg::cmd_t                     cmd_i,
  input  logic [ps2mpt_pkg::ByteW-1:0]         rx_byte_i,
  output ps2mpt_pkg::sts_t                     sts_o,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic [1:0]                           out_kind_o,
  output logic [ps2mpt_pkg::DataW-1:0]         out_data_o,
  output logic                                 out_last_o
);

  localparam int AxisW  = ps2mpt_pkg::AxisW;
  localparam int AbsW   = ps2mpt_pkg::AbsW;
  localparam int ProdW  = ps2mpt_pkg::ProdW;
  localparam int MagW   = ps2mpt_pkg::MagW;
  localparam int QuotW  = ps2mpt_pkg::QuotW;
  localparam int CoordW = ps2mpt_pkg::CoordW;
  localparam int SumW   = ps2mpt_pkg::SumW;
  localparam int MoveW  = ps2mpt_pkg::MoveW;
  localparam int PendW  = ps2mpt_pkg::PendW;
  localparam int ByteW  = ps2mpt_pkg::ByteW;
  localparam int PadW   = ps2mpt_pkg::DataW - 2 * CoordW - 2 * MoveW - 2;

  // Packet and motion state.
  logic [ByteW-1:0]         hdr_q, xb_q;
  logic signed [AxisW-1:0]  dx_q, dx_d, dy_q, dy_d;
  logic [ProdW-1:0]         prod_q;
  logic                     neg_q;
  logic [QuotW-1:0]         q0_q;
  logic [MagW-1:0]          mag_q, mag_d;
  logic signed [CoordW-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [ps2mpt_pkg::NumBtn-1:0] btn_q, btn_d;
  logic [PendW-1:0]         pend_q, pend_d;

  // Output register.
  logic                     out_valid_q, out_valid_d;
  ps2mpt_pkg::ev_kind_e     out_kind_q;
  logic signed [CoordW-1:0] out_x_q, out_y_q;
  logic signed [MoveW-1:0]  out_dx_q, out_dy_q;
  logic signed [MoveW-1:0]  adx_q, adx_d, ady_q, ady_d;
  logic [1:0]               out_btn_q;
  logic                     out_last_q;

  // Load of the raw moves.
  logic signed [AxisW-1:0] raw_x, raw_y;
  assign raw_x = {{(AxisW - ByteW){hdr_q[ps2mpt_pkg::HdrXSign]}}, xb_q};
  assign raw_y = {{(AxisW - ByteW){hdr_q[ps2mpt_pkg::HdrYSign]}}, rx_byte_i};

  // Shared multiplier.
  logic signed [AxisW-1:0] abs_x_full, abs_y_full, sel_v;
  logic [AbsW-1:0]         abs_x, abs_y, abs_sel, mul_a, mul_b;
  logic [2*AbsW-1:0]       mul_p;
  logic [ps2mpt_pkg::GainW-1:0] gain;

  assign abs_x_full = dx_q[AxisW-1] ? -dx_q : dx_q;
  assign abs_y_full = dy_q[AxisW-1] ? -dy_q : dy_q;
  assign abs_x      = abs_x_full[AbsW-1:0];
  assign abs_y      = abs_y_full[AbsW-1:0];
  assign sel_v      = cmd_i.axis ? dy_q : dx_q;
  assign abs_sel    = cmd_i.axis ? abs_y : abs_x;
  assign gain       = cmd_i.gain_acc ? cfg_i.accel : cfg_i.sens;

  always_comb begin
    unique case (cmd_i.op)
      ps2mpt_pkg::OP_SQ: begin
        mul_a = abs_x;
        mul_b = abs_x;
      end
      ps2mpt_pkg::OP_MAG: begin
        mul_a = abs_y;
        mul_b = abs_y;
      end
      default: begin
        mul_a = abs_sel;
        mul_b = AbsW'(gain);
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Divide by one hundred: reciprocal multiply, then one correction step.
  logic [ProdW+ps2mpt_pkg::RecipW-1:0] recip_p;
  logic [ProdW:0]                      hund, rem;
  logic                                fix;
  logic [QuotW-1:0]                    quot;
  logic signed [AxisW-1:0]             quot_s;

  assign recip_p = prod_q * ps2mpt_pkg::DivRecip;
  assign hund    = (ProdW + 1)'(q0_q) * (ProdW + 1)'(ps2mpt_pkg::Divisor);
  assign rem     = {1'b0, prod_q} - hund;
  assign fix     = rem >= (ProdW + 1)'(ps2mpt_pkg::Divisor);
  assign quot    = q0_q + QuotW'(fix);
  assign quot_s  = neg_q ? -$signed(quot) : $signed(quot);

  logic [MagW-1:0] mag_sum;
  assign mag_sum = mag_q + mul_p[MagW-1:0];

  // Clamp against the bounds.
  logic signed [SumW-1:0]   sum_x, sum_y, lo_x, hi_x, lo_y, hi_y, cl_x, cl_y;
  logic signed [CoordW-1:0] nx, ny;

  assign sum_x = SumW'(cur_x_q) + SumW'(dx_q);
  assign sum_y = SumW'(cur_y_q) + SumW'(dy_q);
  assign lo_x  = SumW'(cfg_i.left);
  assign hi_x  = SumW'(cfg_i.right);
  assign lo_y  = SumW'(cfg_i.bottom);
  assign hi_y  = SumW'(cfg_i.top);

  always_comb begin
    priority if (sum_x < lo_x) cl_x = lo_x;
    else if (sum_x > hi_x)     cl_x = hi_x;
    else                       cl_x = sum_x;
    priority if (sum_y < lo_y) cl_y = lo_y;
    else if (sum_y > hi_y)     cl_y = hi_y;
    else                       cl_y = sum_y;
  end

  // A clamped value is always a bound or lies between the bounds, so it fits a coordinate.
  assign nx = cl_x[CoordW-1:0];
  assign ny = cl_y[CoordW-1:0];

  // Event selection: the lowest pending slot goes out first.
  logic [PendW-1:0]     slot_oh, pend_rest;
  logic [1:0]           slot_btn;
  ps2mpt_pkg::ev_kind_e slot_kind;

  assign slot_oh   = pend_q & (~pend_q + PendW'(1));
  assign pend_rest = pend_q & ~slot_oh;

  always_comb begin
    priority if (pend_q[0]) begin
      slot_btn  = 2'd0;
      slot_kind = ps2mpt_pkg::EV_MOVE;
    end else if (pend_q[1]) begin
      slot_btn  = 2'd0;
      slot_kind = btn_q[0] ? ps2mpt_pkg::EV_PRESS : ps2mpt_pkg::EV_RELEASE;
    end else if (pend_q[2]) begin
      slot_btn  = 2'd1;
      slot_kind = btn_q[1] ? ps2mpt_pkg::EV_PRESS : ps2mpt_pkg::EV_RELEASE;
    end else begin
      slot_btn  = 2'd2;
      slot_kind = btn_q[2] ? ps2mpt_pkg::EV_PRESS : ps2mpt_pkg::EV_RELEASE;
    end
  end

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    dx_d        = dx_q;
    dy_d        = dy_q;
    mag_d       = mag_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    btn_d       = btn_q;
    pend_d      = pend_q;
    adx_d       = adx_q;
    ady_d       = ady_q;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (cmd_i.op)
      ps2mpt_pkg::OP_LOAD: begin
        dx_d = cfg_i.inv_h ? -raw_x : raw_x;
        dy_d = cfg_i.inv_v ? raw_y : -raw_y;
      end
      ps2mpt_pkg::OP_QUOT: begin
        if (cmd_i.axis) dy_d = quot_s;
        else            dx_d = quot_s;
      end
      ps2mpt_pkg::OP_SQ:  mag_d = mul_p[MagW-1:0];
      ps2mpt_pkg::OP_MAG: mag_d = mag_sum;
      ps2mpt_pkg::OP_CLAMP: begin
        cur_x_d = nx;
        cur_y_d = ny;
        adx_d   = MoveW'(nx) - MoveW'(cur_x_q);
        ady_d   = MoveW'(ny) - MoveW'(cur_y_q);
        btn_d   = hdr_q[ps2mpt_pkg::NumBtn-1:0];
        pend_d  = {hdr_q[ps2mpt_pkg::NumBtn-1:0] ^ btn_q, (nx != cur_x_q) || (ny != cur_y_q)};
      end
      ps2mpt_pkg::OP_EMIT: begin
        pend_d      = pend_rest;
        out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q       <= '0;
      xb_q        <= '0;
      cur_x_q     <= ps2mpt_pkg::CursorXReset;
      cur_y_q     <= ps2mpt_pkg::CursorYReset;
      btn_q       <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.hdr_we) hdr_q <= rx_byte_i;
      if (cmd_i.xb_we)  xb_q  <= rx_byte_i;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      btn_q       <= btn_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers and output payload carry no reset.
  always_ff @(posedge clk_i) begin
    dx_q  <= dx_d;
    dy_q  <= dy_d;
    mag_q <= mag_d;
    adx_q <= adx_d;
    ady_q <= ady_d;
    if (cmd_i.op == ps2mpt_pkg::OP_MUL) begin
      prod_q <= mul_p[ProdW-1:0];
      neg_q  <= sel_v[AxisW-1];
    end
    if (cmd_i.op == ps2mpt_pkg::OP_RECIP) begin
      q0_q <= recip_p[ps2mpt_pkg::RecipShift +: QuotW];
    end
    if (cmd_i.op == ps2mpt_pkg::OP_EMIT) begin
      out_kind_q <= slot_kind;
      out_x_q    <= cur_x_q;
      out_y_q    <= cur_y_q;
      out_dx_q   <= pend_q[0] ? adx_q : '0;
      out_dy_q   <= pend_q[0] ? ady_q : '0;
      out_btn_q  <= slot_btn;
      out_last_q <= (pend_rest == '0);
    end
  end

  assign sts_o.hdr_ok    = hdr_q[ps2mpt_pkg::HdrSyncBit];
  assign sts_o.mag_big   = mag_sum > MagW'(ps2mpt_pkg::MagLimit);
  assign sts_o.pend_any  = |pend_q;
  assign sts_o.pend_last = (pend_rest == '0);
  assign sts_o.out_free  = out_free;

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_last_o  = out_last_q;
  assign out_data_o  = {{PadW{1'b0}}, out_btn_q, out_dy_q, out_dx_q, out_y_q, out_x_q};

  // The reciprocal estimate is never more than one short of the quotient.
  a_quot_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == ps2mpt_pkg::OP_QUOT |-> rem < (ProdW + 1)'(2 * ps2mpt_pkg::Divisor))
    else $error("divide-by-100 remainder out of range");

  // A move word is only sent when the position really changed.
  a_move_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == ps2mpt_pkg::OP_EMIT && slot_oh[0]
      |=> (out_dx_q != '0 || out_dy_q != '0))
    else $error("move word without any change in position");

  // Button words carry no movement.
  a_btn_nomove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_kind_q != ps2mpt_pkg::EV_MOVE
      |-> (out_dx_q == '0 && out_dy_q == '0))
    else $error("button word with nonzero movement");

  // Pending slots are only ever added by the clamp step.
  a_pend_shrink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op != ps2mpt_pkg::OP_CLAMP |=> (pend_q & ~$past(pend_q)) == '0)
    else $error("pending event appeared outside the clamp step");

endmodule

FILE: tb/sv/ps2_mouse_packet_tracker_tb.sv
// Self-checking testbench for the PS/2 mouse packet tracker.
// Drives link bytes and register writes, predicts every event and compares it.
// Depends on ps2mpt_pkg and the ps2_mouse_packet_tracker RTL.
module ps2_mouse_packet_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ps2mpt_pkg::*;

  localparam int HalfPeriod   = 4;
  localparam int ResetCycles  = 5;
  localparam int SettleCycles = 40;
  localparam int DrainCycles  = 5000;
  localparam int CycleLimit   = 400000;

  typedef struct {
    ev_kind_e                 kind;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [MoveW-1:0]  dx;
    logic signed [MoveW-1:0]  dy;
    logic [1:0]               button;
    logic                     last;
  } mouse_event_t;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                link_valid = 1'b0;
  logic                link_ready;
  logic [ByteW-1:0]    link_data  = '0;
  logic                evt_valid;
  logic                evt_ready  = 1'b0;
  logic [DataW-1:0]    evt_data;
  logic [1:0]          evt_kind;
  logic                evt_last;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index  = '0;
  logic [CfgDataW-1:0] cfg_data   = '0;

  ps2_mouse_packet_tracker u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (link_valid),
    .s_axis_tready_o (link_ready),
    .s_axis_tdata_i  (link_data),
    .m_axis_tvalid_o (evt_valid),
    .m_axis_tready_i (evt_ready),
    .m_axis_tdata_o  (evt_data),
    .m_axis_tuser_o  (evt_kind),
    .m_axis_tlast_o  (evt_last),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  // Tracker state as the testbench sees it.
  cfg_t       tracker_cfg;
  int         byte_slot;
  logic [7:0] held_header;
  logic [7:0] held_x;
  longint     cursor_x;
  longint     cursor_y;
  logic [2:0] held_buttons;

  logic [7:0]   link_bytes[$];
  mouse_event_t expected_events[$];

  bit idle_en = 1'b1;
  int link_gap;
  int sink_gap;
  int err_cnt;
  int bytes_taken;
  int packets_decoded;
  int events_checked;
  int reg_writes;
  int cycle_cnt;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  function automatic longint fit_to_bounds(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic reset_tracker();
    tracker_cfg.sens   = 10'd100;
    tracker_cfg.accel  = 10'd100;
    tracker_cfg.inv_h  = 1'b0;
    tracker_cfg.inv_v  = 1'b0;
    tracker_cfg.left   = 16'sd0;
    tracker_cfg.bottom = 16'sd0;
    tracker_cfg.right  = 16'sd799;
    tracker_cfg.top    = 16'sd599;
    byte_slot    = 0;
    held_header  = '0;
    held_x       = '0;
    cursor_x     = 400;
    cursor_y     = 300;
    held_buttons = '0;
  endtask

  // Works out the events that one accepted link byte causes.
  task automatic track_byte(input logic [7:0] b);
    longint       dx, dy, mag, nx, ny, adx, ady;
    logic [2:0]   pkt_buttons, changed;
    mouse_event_t ev;
    mouse_event_t evs[$];
    if (byte_slot == 0) begin
      held_header = b;
      byte_slot = 1;
    end else if (byte_slot == 1) begin
      held_x = b;
      byte_slot = 2;
    end else begin
      byte_slot = 0;
      if (held_header[HdrSyncBit]) begin
        packets_decoded++;
        pkt_buttons = held_header[2:0];
        dx = longint'(held_x);
        dy = longint'(b);
        if (held_header[HdrXSign]) dx -= 256;
        if (held_header[HdrYSign]) dy -= 256;
        dy = -dy;
        if (tracker_cfg.inv_h) dx = -dx;
        if (tracker_cfg.inv_v) dy = -dy;
        dx = (dx * longint'(tracker_cfg.sens)) / 100;
        dy = (dy * longint'(tracker_cfg.sens)) / 100;
        mag = dx * dx + dy * dy;
        if (mag > 100) begin
          dx = (dx * longint'(tracker_cfg.accel)) / 100;
          dy = (dy * longint'(tracker_cfg.accel)) / 100;
        end
        nx = fit_to_bounds(cursor_x + dx, longint'($signed(tracker_cfg.left)),
                           longint'($signed(tracker_cfg.right)));
        ny = fit_to_bounds(cursor_y + dy, longint'($signed(tracker_cfg.bottom)),
                           longint'($signed(tracker_cfg.top)));
        adx = nx - cursor_x;
        ady = ny - cursor_y;
        cursor_x = nx;
        cursor_y = ny;
        ev.pos_x  = cursor_x[CoordW-1:0];
        ev.pos_y  = cursor_y[CoordW-1:0];
        ev.last   = 1'b0;
        if (adx != 0 || ady != 0) begin
          ev.kind   = EV_MOVE;
          ev.dx     = adx[MoveW-1:0];
          ev.dy     = ady[MoveW-1:0];
          ev.button = 2'd0;
          evs.push_back(ev);
        end
        changed = pkt_buttons ^ held_buttons;
        for (int i = 0; i < NumBtn; i++) begin
          if (changed[i]) begin
            ev.kind   = pkt_buttons[i] ? EV_PRESS : EV_RELEASE;
            ev.dx     = '0;
            ev.dy     = '0;
            ev.button = i[1:0];
            evs.push_back(ev);
          end
        end
        held_buttons = pkt_buttons;
        if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
        foreach (evs[k]) expected_events.push_back(evs[k]);
      end
    end
  endtask

  task automatic check_event();
    mouse_event_t             want;
    logic signed [CoordW-1:0] got_x, got_y;
    logic signed [MoveW-1:0]  got_dx, got_dy;
    logic [1:0]               got_btn;
    got_x   = evt_data[15:0];
    got_y   = evt_data[31:16];
    got_dx  = evt_data[48:32];
    got_dy  = evt_data[65:49];
    got_btn = evt_data[67:66];
    events_checked++;
    if (expected_events.size() == 0) begin
      report_mismatch("event with nothing expected, kind", longint'(evt_kind), -1);
    end else begin
      want = expected_events.pop_front();
      if (evt_kind !== want.kind) report_mismatch("event_kind", evt_kind, want.kind);
      if (got_x !== want.pos_x) report_mismatch("pos_x", got_x, want.pos_x);
      if (got_y !== want.pos_y) report_mismatch("pos_y", got_y, want.pos_y);
      if (got_dx !== want.dx) report_mismatch("move_dx", got_dx, want.dx);
      if (got_dy !== want.dy) report_mismatch("move_dy", got_dy, want.dy);
      if (got_btn !== want.button) report_mismatch("button_number", got_btn, want.button);
      if (evt_last !== want.last) report_mismatch("last_of_run", evt_last, want.last);
      if (evt_data[71:68] !== 4'd0) report_mismatch("tdata padding", evt_data[71:68], 0);
    end
  endtask

  // Link byte driver.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      link_valid <= 1'b0;
    end else begin
      if (link_valid && link_ready) begin
        track_byte(link_data);
        bytes_taken++;
      end
      if (!link_valid || link_ready) begin
        if (link_gap > 0) begin
          link_gap--;
          link_valid <= 1'b0;
        end else if (link_bytes.size() > 0) begin
          link_valid <= 1'b1;
          link_data  <= link_bytes.pop_front();
          if (idle_en && $urandom_range(0, 5) == 0) link_gap = $urandom_range(1, 10);
        end else begin
          link_valid <= 1'b0;
        end
      end
    end
  end

  // Event monitor with random back-pressure.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (evt_valid && evt_ready) check_event();
      if (sink_gap > 0) begin
        sink_gap--;
        evt_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        sink_gap = $urandom_range(0, 9);
        evt_ready <= 1'b0;
      end else begin
        evt_ready <= 1'b1;
      end
    end
  end

  // Called at a rising edge; leaves cfg_valid high for the caller to lower.
  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    reg_writes++;
    case (idx)
      CFG_SENS:   tracker_cfg.sens   = val[GainW-1:0];
      CFG_ACCEL:  tracker_cfg.accel  = val[GainW-1:0];
      CFG_INV_H:  tracker_cfg.inv_h  = val[0];
      CFG_INV_V:  tracker_cfg.inv_v  = val[0];
      CFG_LEFT:   tracker_cfg.left   = val;
      CFG_BOTTOM: tracker_cfg.bottom = val;
      CFG_RIGHT:  tracker_cfg.right  = val;
      CFG_TOP:    tracker_cfg.top    = val;
      default: ;
    endcase
  endtask

  // Waits until every byte is taken and every expected word has arrived, then
  // lets the block finish a packet that produces no events. The queues and the
  // link valid are sampled at the falling edge, where the driver has settled.
  task automatic drain_block();
    int waited;
    waited = 0;
    while (link_bytes.size() != 0 || link_valid) @(negedge clk_i);
    while (expected_events.size() != 0 && waited < DrainCycles) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [15:0] sens, input logic [15:0] accel,
                                input logic [15:0] inv_h, input logic [15:0] inv_v,
                                input logic [15:0] left, input logic [15:0] bottom,
                                input logic [15:0] right, input logic [15:0] top);
    drain_block();
    @(posedge clk_i);
    write_reg(CFG_SENS, sens);
    write_reg(CFG_ACCEL, accel);
    write_reg(CFG_INV_H, inv_h);
    write_reg(CFG_INV_V, inv_v);
    write_reg(CFG_LEFT, left);
    write_reg(CFG_BOTTOM, bottom);
    write_reg(CFG_RIGHT, right);
    write_reg(CFG_TOP, top);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_packet(input logic [7:0] hdr, input logic [7:0] xb, input logic [7:0] yb);
    link_bytes.push_back(hdr);
    link_bytes.push_back(xb);
    link_bytes.push_back(yb);
  endtask

  // Mostly well-formed packets; a few dropped headers and stray bytes that
  // shift the framing. Strays are padded at the end so the next phase starts
  // on a header.
  task automatic queue_random(input int n);
    logic [7:0] hdr, xb, yb;
    int         i, roll, strays, sv;
    strays = 0;
    for (i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        link_bytes.push_back(8'($urandom));
        strays++;
      end
      hdr = 8'($urandom);
      hdr[HdrSyncBit] = (roll >= 12);
      if ($urandom_range(0, 2) == 0) begin
        sv = int'($urandom_range(0, 14)) - 7;
        xb = sv[7:0];
        hdr[HdrXSign] = (sv < 0);
        sv = int'($urandom_range(0, 14)) - 7;
        yb = sv[7:0];
        hdr[HdrYSign] = (sv < 0);
      end else begin
        xb = 8'($urandom);
        yb = 8'($urandom);
      end
      queue_packet(hdr, xb, yb);
    end
    while (strays % 3 != 0) begin
      link_bytes.push_back(8'($urandom));
      strays++;
    end
  endtask

  initial begin
    for (cycle_cnt = 0; cycle_cnt < CycleLimit; cycle_cnt++) @(posedge clk_i);
    $display("timeout after %0d cycles", CycleLimit);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    reset_tracker();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed packets at the reset settings.
    queue_packet(8'h08, 8'h00, 8'h00);  // valid, no motion, no buttons: no events
    queue_packet(8'h09, 8'h7F, 8'h00);  // largest positive X, left press
    queue_packet(8'hFF, 8'h00, 8'h00);  // overflow bits set, most negative moves
    queue_packet(8'h07, 8'hFF, 8'hFF);  // sync bit clear: dropped
    queue_packet(8'h38, 8'h01, 8'hFF);  // both signs, releases all buttons
    queue_packet(8'h18, 8'h80, 8'h80);  // drives X into the left bound
    queue_packet(8'h08, 8'h05, 8'h05);  // small move, no acceleration
    queue_packet(8'h08, 8'h06, 8'h08);  // squared magnitude exactly at the limit
    queue_packet(8'h2A, 8'h7F, 8'h01);  // large move up with right press
    queue_random(10);

    apply_settings(16'd1, 16'd1000, 16'd1, 16'd0, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
    queue_random(8);

    // Zero gains: no movement, buttons only.
    apply_settings(16'd0, 16'd0, 16'd0, 16'd1, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
    queue_random(6);

    // Largest gains with crossed bounds on both axes.
    apply_settings(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'h7FFF, 16'd100, 16'h8000,
                   -16'sd100);
    queue_random(8);

    // Tight bounds that pin the cursor to a point.
    apply_settings(16'd1000, 16'd1, 16'd1, 16'd1, 16'd5, -16'sd5, 16'd5, -16'sd5);
    queue_random(8);

    for (int p = 0; p < 5; p++) begin
      apply_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      queue_random(8);
    end

    apply_settings(16'd100, 16'd100, 16'd0, 16'd0, -16'sd1000, -16'sd1000, 16'd1000,
                   16'd1000);
    idle_en = 1'b0;
    queue_random(10);

    drain_block();
    if (expected_events.size() != 0)
      report_mismatch("events still expected at the end", expected_events.size(), 0);
    $display("run: %0d link bytes, %0d packets decoded, %0d events checked, %0d reg writes",
             bytes_taken, packets_decoded, events_checked, reg_writes);
    $display("covered zero and largest gains, inversion, crossed and pinned bounds, drops");
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/ps2mpt_pkg.sv
hw/rtl/ps2mpt_cfg.sv
hw/rtl/ps2mpt_ctrl.sv
hw/rtl/ps2mpt_dpath.sv
hw/rtl/ps2_mouse_packet_tracker.sv
tb/sv/ps2_mouse_packet_tracker_tb.sv
